// ===== rtl/core/ritoa_pkg.sv =====
// Package for the radix integer to ASCII converter.
// Holds default sizes, the prefix and radix limits and the digit glyph function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ritoa_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int DEFAULT_MAX_DIGITS = 32;

    // Dividend bits consumed by the divider in one cycle.
    localparam int STEP_BITS = 8;

    localparam logic [7:0] PREFIX_NONE = 8'h20;
    localparam logic [4:0] RADIX_MIN   = 5'd2;
    localparam logic [4:0] RADIX_MAX   = 5'd16;

    localparam logic [7:0] GLYPH_ZERO   = 8'h30;
    localparam logic [7:0] GLYPH_LETTER = 8'h37;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] base_char;
        base_char = (d < 4'd10) ? GLYPH_ZERO : GLYPH_LETTER;
        return base_char + {4'd0, d};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/radix_integer_to_ascii.sv =====
// Top level of the radix integer to ASCII converter.
// Depends on ritoa_pkg and ritoa_ram.
//
//   Channel | Direction | Fields
//   s_      | in        | tdata: value[31:0], radix[36:32], sign_char[44:37]
//   m_      | out       | tdata: char_out[7:0]; tlast: last
//
// An item is taken only while the block is idle. Each digit is one long
// division of the value by the radix in the shared divider, which handles 8
// dividend bits per cycle. Output then sends the prefix unless it is
// PREFIX_NONE, and each digit character through a read state and a load
// state, the character coming from the digit RAM. A stalled output holds the
// current item and the sequencer waits. Reset is synchronous and active low;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module radix_integer_to_ascii
    import ritoa_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS,
    parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,  // value[31:0], radix[36:32], sign_char[44:37], zero fill
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,  // char_out[7:0]
    output logic        m_tlast
);

    localparam int NCH      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS = NCH * STEP_BITS;
    localparam int CW       = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int NW       = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_PREFIX = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [PAD_BITS-1:0] div_reg, div_next;
    logic [3:0]          rem_reg, rem_next;
    logic [4:0]          base_reg, base_next;
    logic [7:0]          prefix_reg, prefix_next;
    logic [CW-1:0]       chunk_reg, chunk_next;
    logic [NW-1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_data_reg, out_data_next;
    logic                out_last_reg, out_last_next;

    logic [VALUE_BITS+31:0] value_wide;
    logic [PAD_BITS-1:0]    value_load;
    logic [4:0]             radix_in;
    logic [4:0]             radix_clamped;
    logic [STEP_BITS-1:0]   quot_chunk;
    logic [3:0]             rem_step;
    logic [PAD_BITS-1:0]    quot_next;
    logic                   out_free;
    logic                   digit_we;
    logic [3:0]             digit_rd;
    logic                   s_accept;

    assign s_accept      = s_tvalid && s_tready;
    assign s_tready      = (state_reg == ST_IDLE);
    assign value_wide    = {VALUE_BITS'(0), s_tdata[31:0]};
    assign value_load    = PAD_BITS'(value_wide[VALUE_BITS-1:0]);
    assign radix_in      = s_tdata[36:32];
    assign radix_clamped = (radix_in < RADIX_MIN) ? RADIX_MIN :
                           (radix_in > RADIX_MAX) ? RADIX_MAX : radix_in;
    assign out_free      = !out_valid_reg || m_tready;
    assign digit_we      = (state_reg == ST_DIV) && (chunk_reg == CW'(NCH - 1));

    // Long division by a base of at most 16: the partial remainder stays
    // below the base, so each bit step is a 5-bit compare and subtract.
    always_comb begin
        logic [4:0] trial;
        logic [3:0] r;
        r = rem_reg;
        quot_chunk = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {r, div_reg[PAD_BITS-1-i]};
            if (trial >= base_reg) begin
                trial = trial - base_reg;
                quot_chunk[STEP_BITS-1-i] = 1'b1;
            end
            r = trial[3:0];
        end
        rem_step  = r;
        quot_next = (div_reg << STEP_BITS) | PAD_BITS'(quot_chunk);
    end

    always_comb begin
        state_next     = state_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        prefix_next    = prefix_reg;
        chunk_next     = chunk_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    div_next    = value_load;
                    rem_next    = '0;
                    base_next   = radix_clamped;
                    prefix_next = s_tdata[44:37];
                    chunk_next  = '0;
                    cnt_next    = '0;
                    state_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                div_next = quot_next;
                if (chunk_reg == CW'(NCH - 1)) begin
                    chunk_next = '0;
                    rem_next   = '0;
                    cnt_next   = cnt_reg + NW'(1);
                    ptr_next   = cnt_reg[AW-1:0];
                    if (quot_next == '0 || cnt_reg == NW'(MAX_DIGITS - 1)) begin
                        state_next = (prefix_reg != PREFIX_NONE) ? ST_PREFIX : ST_RD;
                    end
                end else begin
                    chunk_next = chunk_reg + CW'(1);
                    rem_next   = rem_step;
                end
            end
            ST_PREFIX: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = prefix_reg;
                    out_last_next  = 1'b0;
                    state_next     = ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = digit_glyph(digit_rd);
                    out_last_next  = (ptr_reg == '0);
                    if (ptr_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next   = ptr_reg - AW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        base_reg     <= base_next;
        prefix_reg   <= prefix_next;
        ptr_reg      <= ptr_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    ritoa_ram #(
        .WIDTH (4),
        .DEPTH (MAX_DIGITS)
    ) u_digit_ram (
        .aclk  (aclk),
        .we    (digit_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (rem_step),
        .raddr (ptr_reg),
        .rdata (digit_rd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // The running remainder must stay below the base while dividing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < base_reg))
        else $error("remainder not below base");

    // The digit count never passes the store depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= NW'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    // Loading the final character of a number returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && out_free && ptr_reg == '0) |=>
            (state_reg == ST_IDLE && m_tvalid && m_tlast))
        else $error("final character did not end the item");

    // A taken input item starts a fresh division.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_DIV && cnt_reg == '0 && chunk_reg == '0))
        else $error("division did not start after input");

endmodule

`default_nettype wire

// ===== rtl/core/ritoa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ritoa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire                                       aclk,
    input  wire                                       we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                          wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
